// ----- design/task_dependency_scheduler_core_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef TASK_DEPENDENCY_SCHEDULER_CORE_MACROS_SVH
`define TASK_DEPENDENCY_SCHEDULER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TDS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("scheduler invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define TDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler sequencing violated");

`endif

// ----- design/tds_pkg.sv -----
// Types and constants of the task dependency scheduler.
`timescale 1ns / 1ps
package tds_pkg;

   localparam int ID_W     = 16;
   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 7;

   localparam logic [ID_W-1:0]    ID_NONE    = '1;
   localparam logic [COUNT_W-1:0] COUNT_INIT = 7'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;

   localparam logic [2:0] REQ_BEGIN_ADD  = 3'd0;
   localparam logic [2:0] REQ_FINISH_ADD = 3'd1;
   localparam logic [2:0] REQ_ADD_CHILD  = 3'd2;
   localparam logic [2:0] REQ_DISPATCH   = 3'd3;
   localparam logic [2:0] REQ_COMPLETE   = 3'd4;
   localparam logic [2:0] REQ_QUERY      = 3'd5;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SLOT    = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [1:0] ST_NONE_READY = 2'd3;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [ID_W-1:0]     task_id;
      logic [ID_W-1:0]     other_id;
      logic [HANDLE_W-1:0] work_handle;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ID_W-1:0]     result_id;
      logic [HANDLE_W-1:0] result_handle;
      logic                is_open;
   } rsp_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]     task_id;
      logic [ID_W-1:0]     parent;
      logic [ID_W-1:0]     dependency;
      logic [COUNT_W-1:0]  count;
      logic [HANDLE_W-1:0] handle;
   } slot_rec_type;

endpackage

// ----- design/task_dependency_scheduler_core.sv -----
// Task dependency scheduler: slot pool, free stack and request sequencer.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_payload (req_payload_type)
//   rsp      out        rsp_valid / rsp_ready   rsp_payload (rsp_payload_type)
//
// One request at a time. Each id lookup, dispatch or held-dependent release scans
// the slot memory one slot per cycle; a lookup stops at the match. A completion that
// frees k tasks costs about (k + 1) lookups plus k release scans. The single-port
// slot read sets this cost. Reset is synchronous; no clearing pass. A new request
// is taken while the previous result still waits on rsp; a finished result waits
// for rsp_ready.
`timescale 1ns / 1ps
module task_dependency_scheduler_core #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tds_pkg::req_payload_type   req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tds_pkg::rsp_payload_type   rsp_payload
);
   import tds_pkg::*;

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int TW = $clog2(NUM_SLOTS + 1);
   localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);
   localparam logic [TW-1:0] FULL = TW'(NUM_SLOTS);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_STK      = 4'd1;
   localparam logic [3:0] S_FIND     = 4'd2;
   localparam logic [3:0] S_DISP     = 4'd3;
   localparam logic [3:0] S_CHAIN    = 4'd4;
   localparam logic [3:0] S_POP      = 4'd5;
   localparam logic [3:0] S_REL_RD   = 4'd6;
   localparam logic [3:0] S_REL_ID   = 4'd7;
   localparam logic [3:0] S_REL_SCAN = 4'd8;
   localparam logic [3:0] S_REL_FIN  = 4'd9;
   localparam logic [3:0] S_AC_S     = 4'd10;
   localparam logic [3:0] S_AC_C     = 4'd11;
   localparam logic [3:0] S_RESP     = 4'd12;

   localparam logic [1:0] R_FIRST  = 2'd0;
   localparam logic [1:0] R_CHILD  = 2'd1;
   localparam logic [1:0] R_PARENT = 2'd2;
   localparam logic [1:0] R_DEP    = 2'd3;

   logic [3:0]            state_ff, state_in;
   req_payload_type       req_ff, req_in;
   rsp_payload_type       res_ff, res_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       key_ff, key_in;
   logic [1:0]            ret_ff, ret_in;
   logic [SW-1:0]         scan_ff, scan_in;
   logic                  scan_iss_ff, scan_iss_in;
   logic [SW-1:0]         s_ff, s_in, c_ff, c_in, cur_ff, cur_in;
   logic [SW-1:0]         rel_ff, rel_in, best_ff, best_in;
   slot_rec_type          s_rec_ff, s_rec_in, c_rec_ff, c_rec_in;
   slot_rec_type          cur_rec_ff, cur_rec_in, best_rec_ff, best_rec_in;
   logic                  best_vld_ff, best_vld_in;
   logic [TW-1:0]         n_ff, n_in;
   logic [TW-1:0]         free_top_ff, free_top_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic [NUM_SLOTS-1:0]  open_ff, open_in, ready_ff, ready_in, held_ff, held_in;
   logic [NUM_SLOTS-1:0]  stack_wr_ff;

   logic [SW-1:0]         stack_mem [NUM_SLOTS];
   logic [SW-1:0]         chain_mem [NUM_SLOTS];
   logic [SW-1:0]         stk_rd_ff, stk_idx_ff, chain_rd_ff;
   logic                  stk_vld_ff;

   logic                  st_we, st_re;
   logic [SW-1:0]         st_waddr, st_raddr;
   slot_rec_type          st_wdata;
   logic                  st_rd_vld;
   logic [SW-1:0]         st_rd_idx;
   slot_rec_type          st_rd_rec;

   logic                  stk_re, stack_we, chain_we, chain_re;
   logic [TW-1:0]         ft_m1, n_m1;
   logic [SW-1:0]         stk_ra;

   logic                  last, hit, key_none, fdone, cand, rel_match;
   logic [SW-1:0]         alloc_slot, b_idx;
   slot_rec_type          tmp_rec, b_rec;
   logic [ID_W-1:0]       nid;

   tds_slot_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_vld  (st_rd_vld),
      .rd_idx  (st_rd_idx),
      .rd_rec  (st_rd_rec)
   );

   assign ft_m1  = free_top_ff - TW'(1);
   assign n_m1   = n_ff - TW'(1);
   assign stk_ra = ft_m1[SW-1:0];

   assign last      = st_rd_vld && (st_rd_idx == LAST);
   assign key_none  = (key_ff == ID_NONE);
   assign hit       = st_rd_vld && open_ff[st_rd_idx] && (st_rd_rec.task_id == key_ff);
   assign fdone     = key_none || hit || last;
   assign cand      = st_rd_vld && open_ff[st_rd_idx] && ready_ff[st_rd_idx] &&
                      (!best_vld_ff || (st_rd_rec.count < best_rec_ff.count));
   assign rel_match = st_rd_vld && open_ff[st_rd_idx] && held_ff[st_rd_idx] &&
                      (st_rd_rec.dependency == key_ff);
   assign alloc_slot = stk_vld_ff ? stk_rd_ff : (LAST - stk_idx_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_in       = key_ff;
      ret_in       = ret_ff;
      scan_in      = scan_ff;
      scan_iss_in  = scan_iss_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      cur_in       = cur_ff;
      rel_in       = rel_ff;
      best_in      = best_ff;
      s_rec_in     = s_rec_ff;
      c_rec_in     = c_rec_ff;
      cur_rec_in   = cur_rec_ff;
      best_rec_in  = best_rec_ff;
      best_vld_in  = best_vld_ff;
      n_in         = n_ff;
      free_top_in  = free_top_ff;
      next_id_in   = next_id_ff;
      open_in      = open_ff;
      ready_in     = ready_ff;
      held_in      = held_ff;
      st_we        = 1'b0;
      st_waddr     = cur_ff;
      st_wdata     = cur_rec_ff;
      st_re        = 1'b0;
      st_raddr     = scan_ff;
      stk_re       = 1'b0;
      stack_we     = 1'b0;
      chain_we     = 1'b0;
      chain_re     = 1'b0;
      tmp_rec      = cur_rec_ff;
      b_idx        = best_ff;
      b_rec        = best_rec_ff;
      nid          = next_id_ff + ID_W'(1);
      req_ready    = (state_ff == S_IDLE);

      if (state_ff == S_FIND || state_ff == S_DISP || state_ff == S_REL_SCAN) begin
         st_re = scan_iss_ff && !(state_ff == S_FIND && (hit || key_none));
         if (st_re) begin
            scan_in = scan_ff + SW'(1);
            if (scan_ff == LAST) begin
               scan_iss_in = 1'b0;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in              = req_payload;
               res_in.status       = ST_OK;
               res_in.result_id    = ID_NONE;
               res_in.result_handle = '0;
               res_in.is_open      = 1'b0;
               key_in              = req_payload.task_id;
               ret_in              = R_FIRST;
               scan_in             = '0;
               scan_iss_in         = 1'b1;
               best_vld_in         = 1'b0;
               unique case (req_payload.req_type)
                  REQ_BEGIN_ADD: begin
                     if (free_top_ff == '0) begin
                        res_in.status = ST_NO_SLOT;
                        state_in      = S_RESP;
                     end else begin
                        stk_re   = 1'b1;
                        state_in = S_STK;
                     end
                  end
                  REQ_FINISH_ADD, REQ_ADD_CHILD, REQ_COMPLETE, REQ_QUERY: begin
                     state_in = S_FIND;
                  end
                  REQ_DISPATCH: begin
                     state_in = S_DISP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_STK: begin
            tmp_rec.task_id    = next_id_ff;
            tmp_rec.parent     = ID_NONE;
            tmp_rec.dependency = req_ff.other_id;
            tmp_rec.count      = COUNT_INIT;
            tmp_rec.handle     = req_ff.work_handle;
            st_we              = 1'b1;
            st_waddr           = alloc_slot;
            st_wdata           = tmp_rec;
            open_in[alloc_slot]  = 1'b1;
            ready_in[alloc_slot] = 1'b0;
            held_in[alloc_slot]  = 1'b0;
            free_top_in        = ft_m1;
            res_in.result_id   = next_id_ff;
            next_id_in         = (nid == ID_NONE) ? '0 : nid;
            state_in           = S_RESP;
         end
         S_FIND: begin
            if (fdone) begin
               scan_in     = '0;
               scan_iss_in = 1'b1;
               unique case (ret_ff)
                  R_FIRST: begin
                     if (!hit) begin
                        if (req_ff.req_type != REQ_QUERY) begin
                           res_in.status = ST_NOT_FOUND;
                        end
                        state_in = S_RESP;
                     end else begin
                        s_in       = st_rd_idx;
                        s_rec_in   = st_rd_rec;
                        cur_in     = st_rd_idx;
                        cur_rec_in = st_rd_rec;
                        n_in       = '0;
                        unique case (req_ff.req_type)
                           REQ_ADD_CHILD: begin
                              key_in   = req_ff.other_id;
                              ret_in   = R_CHILD;
                              state_in = S_FIND;
                           end
                           REQ_QUERY: begin
                              res_in.is_open = 1'b1;
                              state_in       = S_RESP;
                           end
                           default: begin
                              state_in = S_CHAIN;
                           end
                        endcase
                     end
                  end
                  R_CHILD: begin
                     if (!hit) begin
                        res_in.status = ST_NOT_FOUND;
                        state_in      = S_RESP;
                     end else begin
                        c_in     = st_rd_idx;
                        c_rec_in = st_rd_rec;
                        state_in = S_AC_S;
                     end
                  end
                  R_PARENT: begin
                     if (hit) begin
                        cur_in     = st_rd_idx;
                        cur_rec_in = st_rd_rec;
                        state_in   = S_CHAIN;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  R_DEP: begin
                     held_in[s_ff]  = hit;
                     ready_in[s_ff] = !hit;
                     state_in       = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_DISP: begin
            if (cand) begin
               best_in     = st_rd_idx;
               best_rec_in = st_rd_rec;
               best_vld_in = 1'b1;
               b_idx       = st_rd_idx;
               b_rec       = st_rd_rec;
            end
            if (last) begin
               if (best_vld_ff || cand) begin
                  ready_in[b_idx]      = 1'b0;
                  res_in.result_id     = b_rec.task_id;
                  res_in.result_handle = b_rec.handle;
               end else begin
                  res_in.status = ST_NONE_READY;
               end
               state_in = S_RESP;
            end
         end
         S_CHAIN: begin
            if (cur_rec_ff.count == '0) begin
               state_in = S_POP;
            end else begin
               tmp_rec.count    = cur_rec_ff.count - COUNT_W'(1);
               cur_rec_in.count = tmp_rec.count;
               st_we            = 1'b1;
               st_waddr         = cur_ff;
               st_wdata         = tmp_rec;
               if (tmp_rec.count != '0) begin
                  state_in = S_POP;
               end else begin
                  chain_we    = 1'b1;
                  n_in        = n_ff + TW'(1);
                  key_in      = cur_rec_ff.parent;
                  ret_in      = R_PARENT;
                  scan_in     = '0;
                  scan_iss_in = 1'b1;
                  state_in    = S_FIND;
               end
            end
         end
         S_POP: begin
            if (n_ff == '0) begin
               if (req_ff.req_type == REQ_FINISH_ADD && open_ff[s_ff]) begin
                  key_in      = s_rec_ff.dependency;
                  ret_in      = R_DEP;
                  scan_in     = '0;
                  scan_iss_in = 1'b1;
                  state_in    = S_FIND;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               chain_re = 1'b1;
               n_in     = n_m1;
               state_in = S_REL_RD;
            end
         end
         S_REL_RD: begin
            rel_in   = chain_rd_ff;
            st_re    = 1'b1;
            st_raddr = chain_rd_ff;
            state_in = S_REL_ID;
         end
         S_REL_ID: begin
            key_in      = st_rd_rec.task_id;
            scan_in     = '0;
            scan_iss_in = 1'b1;
            state_in    = S_REL_SCAN;
         end
         S_REL_SCAN: begin
            if (rel_match) begin
               held_in[st_rd_idx]  = 1'b0;
               ready_in[st_rd_idx] = 1'b1;
            end
            if (last) begin
               state_in = S_REL_FIN;
            end
         end
         S_REL_FIN: begin
            open_in[rel_ff]  = 1'b0;
            ready_in[rel_ff] = 1'b0;
            held_in[rel_ff]  = 1'b0;
            if (free_top_ff < FULL) begin
               stack_we    = 1'b1;
               free_top_in = free_top_ff + TW'(1);
            end
            state_in = S_POP;
         end
         S_AC_S: begin
            tmp_rec = s_rec_ff;
            if (s_rec_ff.count < COUNT_MAX) begin
               tmp_rec.count = s_rec_ff.count + COUNT_W'(1);
            end
            s_rec_in = tmp_rec;
            st_we    = 1'b1;
            st_waddr = s_ff;
            st_wdata = tmp_rec;
            state_in = S_AC_C;
         end
         S_AC_C: begin
            tmp_rec        = (c_ff == s_ff) ? s_rec_ff : c_rec_ff;
            tmp_rec.parent = req_ff.task_id;
            st_we          = 1'b1;
            st_waddr       = c_ff;
            st_wdata       = tmp_rec;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_re) begin
         stk_rd_ff  <= stack_mem[stk_ra];
         stk_vld_ff <= stack_wr_ff[stk_ra];
         stk_idx_ff <= stk_ra;
      end
      if (stack_we) begin
         stack_mem[free_top_ff[SW-1:0]] <= rel_ff;
      end
      if (chain_we) begin
         chain_mem[n_ff[SW-1:0]] <= cur_ff;
      end
      if (chain_re) begin
         chain_rd_ff <= chain_mem[n_m1[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      key_ff      <= key_in;
      ret_ff      <= ret_in;
      scan_ff     <= scan_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      cur_ff      <= cur_in;
      rel_ff      <= rel_in;
      best_ff     <= best_in;
      s_rec_ff    <= s_rec_in;
      c_rec_ff    <= c_rec_in;
      cur_rec_ff  <= cur_rec_in;
      best_rec_ff <= best_rec_in;
      n_ff        <= n_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_iss_ff  <= 1'b0;
         best_vld_ff  <= 1'b0;
         free_top_ff  <= FULL;
         next_id_ff   <= '0;
         open_ff      <= '0;
         ready_ff     <= '0;
         held_ff      <= '0;
         stack_wr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_iss_ff  <= scan_iss_in;
         best_vld_ff  <= best_vld_in;
         free_top_ff  <= free_top_in;
         next_id_ff   <= next_id_in;
         open_ff      <= open_in;
         ready_ff     <= ready_in;
         held_ff      <= held_in;
         if (stack_we) begin
            stack_wr_ff[free_top_ff[SW-1:0]] <= 1'b1;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "task_dependency_scheduler_core_macros.svh"

   `TDS_ASSERT_ALWAYS(a_slot_conservation, clock, reset, ($countones(open_ff) + int'(free_top_ff)) == NUM_SLOTS)
   `TDS_ASSERT_ALWAYS(a_marks_need_open, clock, reset, ((ready_ff | held_ff) & ~open_ff) == '0)
   `TDS_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != S_IDLE)

endmodule

// ----- design/tds_slot_store.sv -----
// Slot record memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tds_slot_store #(
   parameter int NUM_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  tds_pkg::slot_rec_type        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output logic                         rd_vld,
   output logic [$clog2(NUM_SLOTS)-1:0] rd_idx,
   output tds_pkg::slot_rec_type        rd_rec
);
   import tds_pkg::*;

   localparam int SW = $clog2(NUM_SLOTS);

   slot_rec_type   mem [NUM_SLOTS];
   logic           rd_vld_ff;
   logic [SW-1:0]  rd_idx_ff;
   slot_rec_type   rd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_rec_ff <= mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   assign rd_vld = rd_vld_ff;
   assign rd_idx = rd_idx_ff;
   assign rd_rec = rd_rec_ff;

endmodule
